// ----- rtl/core/qah_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qah_pkg
// Shared constants and types for the quadrilateral area block.
// ---------------------------------------------------------------------------
package qah_pkg;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int AREA_W          = 25;
  // each side root produces one bit per stage
  localparam int SIDE_W          = COORD_WIDTH_DEF + 2;
endpackage
`default_nettype wire

// ----- rtl/core/qah_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qah_isqrt
// Pipelined truncating square root, one result bit per register stage.
// Carries a sideband word along with each value.
// ---------------------------------------------------------------------------
module qah_isqrt #(
  parameter int IN_W = 34,
  parameter int SB_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_vld,
  input  wire logic [IN_W-1:0]   in_val,
  input  wire logic [SB_W-1:0]   in_sb,
  output logic                   out_vld,
  output logic [(IN_W+1)/2-1:0]  out_root,
  output logic [SB_W-1:0]        out_sb
);
  localparam int RW = (IN_W + 1) / 2;
  localparam int VW = 2 * RW;

  logic [RW:0]       vld_r;
  logic [VW-1:0]     rem_r  [RW+1];
  logic [VW-1:0]     val_r  [RW+1];
  logic [RW-1:0]     root_r [RW+1];
  logic [SB_W-1:0]   sb_r   [RW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[RW-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      val_r[0]  <= VW'(in_val);
      root_r[0] <= '0;
      sb_r[0]   <= in_sb;
    end
  end

  // stage k decides root bit RW-1-k by restoring compare on narrow window
  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [VW+1:0] rem_sh;
    logic [VW+1:0] trial;
    always_comb begin
      rem_sh = {rem_r[k], val_r[k][VW-1 -: 2]};
      trial  = {{(VW-RW){1'b0}}, root_r[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        val_r[k+1] <= {val_r[k][VW-3:0], 2'b00};
        sb_r[k+1]  <= sb_r[k];
        if (rem_sh >= trial) begin
          rem_r[k+1]  <= VW'(rem_sh - trial);
          root_r[k+1] <= {root_r[k][RW-2:0], 1'b1};
        end else begin
          rem_r[k+1]  <= VW'(rem_sh);
          root_r[k+1] <= {root_r[k][RW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld  = vld_r[RW];
  assign out_root = root_r[RW];
  assign out_sb   = sb_r[RW];
endmodule
`default_nettype wire

// ----- rtl/core/quad_area_heron.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipeline depth is set by the two bit-per-stage square root pipelines (side roots and
// triangle-area roots) and the Heron product stages.
// Throughput: one request per cycle; the whole pipe holds while out_tvalid is high and out_tready low.
// Reset clears valid bits only; no datapath state survives between requests.
// ---------------------------------------------------------------------------
// quad_area_heron
// Quadrilateral area as two Heron triangles split along diagonal AC.
// ---------------------------------------------------------------------------
module quad_area_heron
  import qah_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y from bit 0 up, zero padded
  input  wire logic [((8*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  // area, radicand_clamped, area_saturated from bit 0 up, zero padded
  output logic [31:0]                   out_tdata
);
  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 1;            // |difference|
  localparam int SQW = 2 * DW + 1;        // sum of squares
  localparam int SW  = (SQW + 1) / 2;     // side length
  localparam int FW  = SW + 2;            // signed factor
  localparam int PW  = 4 * SW + 4;        // product of four factors
  localparam int HS  = 2 * FRAC_BITS + 4;
  localparam int RADW = PW - HS;
  localparam int AW  = (RADW + 1) / 2;

  logic en;
  assign en = out_tready || !out_tvalid;
  assign in_tready = en;

  // stage 1: coordinate differences
  logic signed [CW-1:0] cx [8];
  for (genvar i = 0; i < 8; i++) begin : g_f
    assign cx[i] = in_tdata[i*CW +: CW];
  end
  logic        v1_r;
  logic [DW-1:0] dx_r [5], dy_r [5];
  function automatic logic [DW-1:0] absd(input logic signed [CW-1:0] p,
                                         input logic signed [CW-1:0] q);
    logic signed [DW-1:0] d;
    begin
      d = DW'(q) - DW'(p);
      absd = d[DW-1] ? DW'(-d) : DW'(d);
    end
  endfunction
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r[0] <= absd(cx[0], cx[2]); dy_r[0] <= absd(cx[1], cx[3]); // AB
      dx_r[1] <= absd(cx[2], cx[4]); dy_r[1] <= absd(cx[3], cx[5]); // BC
      dx_r[2] <= absd(cx[0], cx[4]); dy_r[2] <= absd(cx[1], cx[5]); // AC
      dx_r[3] <= absd(cx[4], cx[6]); dy_r[3] <= absd(cx[5], cx[7]); // CD
      dx_r[4] <= absd(cx[0], cx[6]); dy_r[4] <= absd(cx[1], cx[7]); // AD
    end
  end

  // stage 2: squares; stage 3: sum
  logic v2_r, v3_r;
  logic [2*DW-1:0] qx_r [5], qy_r [5];
  logic [SQW-1:0]  sq_r [5];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0; v3_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r; v3_r <= v2_r;
    end
  end
  for (genvar i = 0; i < 5; i++) begin : g_sq
    always_ff @(posedge clk) begin
      if (en) begin
        qx_r[i] <= dx_r[i] * dx_r[i];
        qy_r[i] <= dy_r[i] * dy_r[i];
        sq_r[i] <= SQW'(qx_r[i]) + SQW'(qy_r[i]);
      end
    end
  end

  // side roots
  logic [SW-1:0] side [5];
  logic sv [5];
  for (genvar i = 0; i < 5; i++) begin : g_rt
    logic unused_sb;
    qah_isqrt #(.IN_W(SQW), .SB_W(1)) u_rt (
      .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v3_r), .in_val(sq_r[i]),
      .in_sb(1'b0), .out_vld(sv[i]), .out_root(side[i]), .out_sb(unused_sb)
    );
  end

  // Heron factors per triangle: tri 0 = (AB, BC, AC), tri 1 = (AC, CD, AD)
  logic v4_r;
  logic signed [FW-1:0] fp_r [2], fq_r [2], fr_r [2], ft_r [2];
  function automatic logic signed [FW-1:0] fsum(input logic [SW-1:0] a,
    input logic [SW-1:0] b, input logic [SW-1:0] c, input logic neg_a);
    begin
      fsum = neg_a ? FW'(b) + FW'(c) - FW'(a) : FW'(a) + FW'(b) + FW'(c);
    end
  endfunction
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= sv[0];
  end
  for (genvar t = 0; t < 2; t++) begin : g_fac
    logic [SW-1:0] sa, sb, sc;
    assign sa = t == 0 ? side[0] : side[2];
    assign sb = t == 0 ? side[1] : side[3];
    assign sc = t == 0 ? side[2] : side[4];
    always_ff @(posedge clk) begin
      if (en) begin
        fp_r[t] <= fsum(sa, sb, sc, 1'b0);
        fq_r[t] <= fsum(sa, sb, sc, 1'b1);
        fr_r[t] <= fsum(sb, sa, sc, 1'b1);
        ft_r[t] <= fsum(sc, sa, sb, 1'b1);
      end
    end
  end

  // classify, then two products and the final product in 19-bit slices
  localparam int HW  = 2 * SW + 2;  // pair product width
  localparam int HLW = HW / 2;
  localparam int HHW = HW - HLW;
  logic v5_r, v6_r, v7_r;
  logic [1:0] zero_r, clmp_r, z6_r, c6_r, z7_r, c7_r;
  logic [HW-1:0] pq_r [2], rt_r [2];
  logic [2*HW-1:0] ll_r [2], lh_r [2], hl_r [2], hh_r [2];
  logic [PW-1:0] prod_r [2];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r; v6_r <= v5_r; v7_r <= v6_r;
    end
  end
  for (genvar t = 0; t < 2; t++) begin : g_prod
    logic zf, nf;
    assign zf = fp_r[t] == '0 || fq_r[t] == '0 || fr_r[t] == '0 || ft_r[t] == '0;
    assign nf = fq_r[t][FW-1] || fr_r[t][FW-1] || ft_r[t][FW-1];
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[t] <= zf;
        clmp_r[t] <= !zf && nf;
        pq_r[t]   <= HW'(fp_r[t][FW-2:0]) * HW'(fq_r[t][FW-2:0]);
        rt_r[t]   <= HW'(fr_r[t][FW-2:0]) * HW'(ft_r[t][FW-2:0]);
        z6_r[t] <= zero_r[t]; c6_r[t] <= clmp_r[t];
        ll_r[t] <= (2*HW)'(pq_r[t][HLW-1:0]) * (2*HW)'(rt_r[t][HLW-1:0]);
        lh_r[t] <= (2*HW)'(pq_r[t][HLW-1:0]) * (2*HW)'(rt_r[t][HW-1:HLW]);
        hl_r[t] <= (2*HW)'(pq_r[t][HW-1:HLW]) * (2*HW)'(rt_r[t][HLW-1:0]);
        hh_r[t] <= (2*HW)'(pq_r[t][HW-1:HLW]) * (2*HW)'(rt_r[t][HW-1:HLW]);
        z7_r[t] <= z6_r[t]; c7_r[t] <= c6_r[t];
        prod_r[t] <= PW'(ll_r[t]) + (PW'(lh_r[t]) << HLW) + (PW'(hl_r[t]) << HLW)
                   + (PW'(hh_r[t]) << (2*HLW));
      end
    end
  end

  // triangle area roots; sideband carries zero/clamp info
  logic [AW-1:0] tarea [2];
  logic [1:0]    tsb [2];
  logic          tv [2];
  for (genvar t = 0; t < 2; t++) begin : g_ar
    logic [RADW-1:0] rad;
    assign rad = (z7_r[t] || c7_r[t]) ? '0 : prod_r[t][PW-1:HS];
    qah_isqrt #(.IN_W(RADW), .SB_W(2)) u_ar (
      .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v7_r), .in_val(rad),
      .in_sb({c7_r[t], z7_r[t]}), .out_vld(tv[t]), .out_root(tarea[t]),
      .out_sb(tsb[t])
    );
  end

  // sum, saturate, output register
  localparam logic [AW:0] AMAX = (AW+1)'((64'd1 << AREA_W) - 64'd1);
  logic [AW:0] sum;
  logic        sat;
  assign sum = (AW+1)'(tarea[0]) + (AW+1)'(tarea[1]);
  assign sat = sum > AMAX;
  logic              ov_r;
  logic [AREA_W-1:0] area_r;
  logic              clf_r, sat_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (en) ov_r <= tv[0] && tv[1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      area_r <= sat ? AREA_W'(AMAX) : AREA_W'(sum);
      clf_r  <= tsb[0][1] || tsb[1][1];
      sat_r  <= sat;
    end
  end
  assign out_tvalid = ov_r;
  assign out_tdata  = {5'b0, sat_r, clf_r, area_r};
endmodule
`default_nettype wire

// ----- tb/sv/tb_quad_area_heron.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_quad_area_heron
// Streams corner sets through the quadrilateral area block. Requests without a
// known result are predicted from the coordinates: truncated side roots, then
// Heron's form per triangle; checked in order, with random gaps and stalls.
// ---------------------------------------------------------------------------
module tb_quad_area_heron;
  import qah_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int HERON_SHIFT = 2 * FRAC_BITS_DEF + 4;
  localparam logic [AREA_W-1:0] AREA_TOP = '1;
  localparam int N_RANDOM = 1150;
  localparam int DRAIN_CYCLES = 2 * CW + FRAC_BITS_DEF + 120;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic              clamped;
    logic              saturated;
  } area_res_t;

  typedef struct {
    logic [8*CW-1:0] corners;
    bit              known;
    area_res_t       res;
  } corner_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [8*CW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;

  area_res_t area_q[$];
  int n_fail = 0;
  int n_mismatch = 0;
  int n_results = 0;
  int n_clamped = 0;
  int out_stall = 0;
  bit calm = 1'b0;

  quad_area_heron u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #6 clk = ~clk;

  function automatic logic [127:0] root_floor(input logic [127:0] v);
    logic [127:0] r, b;
    r = '0;
    b = 128'd1 << 126;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - r - b;
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint side_of(input logic signed [CW-1:0] x1, y1, x2, y2);
    longint ddx, ddy;
    ddx = longint'(x2) - longint'(x1);
    ddy = longint'(y2) - longint'(y1);
    return longint'(root_floor(128'(ddx * ddx + ddy * ddy)));
  endfunction

  function automatic longint heron_area(input longint a, b, c, inout bit clamp);
    longint p, q, r, t;
    logic [127:0] prod;
    p = a + b + c;
    q = b + c - a;
    r = a + c - b;
    t = a + b - c;
    if (p == 0 || q == 0 || r == 0 || t == 0) return 0;
    if (q < 0 || r < 0 || t < 0) begin
      clamp = 1'b1;
      return 0;
    end
    prod = 128'(p) * 128'(q) * 128'(r) * 128'(t);
    return longint'(root_floor(prod >> HERON_SHIFT));
  endfunction

  function automatic area_res_t quad_area(input logic [8*CW-1:0] k);
    logic signed [CW-1:0] v[8];
    longint ab, bc, ac, cd, ad, total;
    bit clamp;
    area_res_t res;
    for (int i = 0; i < 8; i++) v[i] = k[i*CW +: CW];
    ab = side_of(v[0], v[1], v[2], v[3]);
    bc = side_of(v[2], v[3], v[4], v[5]);
    ac = side_of(v[0], v[1], v[4], v[5]);
    cd = side_of(v[4], v[5], v[6], v[7]);
    ad = side_of(v[0], v[1], v[6], v[7]);
    clamp = 1'b0;
    total = heron_area(ab, bc, ac, clamp) + heron_area(ac, cd, ad, clamp);
    res.clamped = clamp;
    res.saturated = total > longint'(AREA_TOP);
    res.area = res.saturated ? AREA_TOP : total[AREA_W-1:0];
    return res;
  endfunction

  function automatic logic [8*CW-1:0] corners(input int ax, ay, bx, by, cx, cy, dx, dy);
    logic [CW-1:0] f[8];
    f = '{ax[CW-1:0], ay[CW-1:0], bx[CW-1:0], by[CW-1:0],
          cx[CW-1:0], cy[CW-1:0], dx[CW-1:0], dy[CW-1:0]};
    return {f[7], f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 3))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic logic [8*CW-1:0] random_corners();
    int ax, ay, cx, cy;
    logic [8*CW-1:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        for (int i = 0; i < 8; i++) k[i*CW +: CW] = CW'($urandom);
      end
      3, 4, 5:
        k = corners($urandom_range(0, 1023) - 512, $urandom_range(0, 1023) - 512,
                    $urandom_range(0, 1023) - 512, $urandom_range(0, 1023) - 512,
                    $urandom_range(0, 1023) - 512, $urandom_range(0, 1023) - 512,
                    $urandom_range(0, 1023) - 512, $urandom_range(0, 1023) - 512);
      6, 7, 8: begin
        // near-collinear ABC and ACD so truncated sides break the inequality
        ax = $urandom_range(0, 32000) - 16000;
        ay = $urandom_range(0, 32000) - 16000;
        cx = ax + $urandom_range(0, 64) - 32;
        cy = ay + $urandom_range(0, 64) - 32;
        k = corners(ax, ay, (ax + cx) / 2 + $urandom_range(0, 2) - 1,
                    (ay + cy) / 2 + $urandom_range(0, 2) - 1, cx, cy,
                    (ax + cx) / 2 + $urandom_range(0, 2) - 1,
                    (ay + cy) / 2 + $urandom_range(0, 2) - 1);
      end
      default:
        k = corners(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                    pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
    endcase
    return k;
  endfunction

  // drive one request; entered and left at a falling edge
  task automatic send_corners(input logic [8*CW-1:0] k, input bit known,
                              input area_res_t res);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= k;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    area_q.push_back(known ? res : quad_area(k));
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    area_res_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.area = out_tdata[AREA_W-1:0];
      got.clamped = out_tdata[AREA_W];
      got.saturated = out_tdata[AREA_W+1];
      n_results++;
      if (got.clamped) n_clamped++;
      if (area_q.size() == 0) begin
        n_fail++;
        $display("unexpected result %h", out_tdata);
      end else begin
        want = area_q.pop_front();
        if (got != want) begin
          n_fail++;
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: area %0d/%0d clamp %0b/%0b sat %0b/%0b (exp/act)",
                     want.area, got.area, want.clamped, got.clamped,
                     want.saturated, got.saturated);
        end
      end
      out_stall <= calm ? 0 : $urandom_range(0, 10);
    end
  end

  initial begin
    #(12 * 600000);
    $display("Verification failed");
    $finish;
  end

  initial begin
    corner_row_t rows[$];
    area_res_t none;
    area_res_t clamp_only;
    none = '{area: '0, clamped: 1'b0, saturated: 1'b0};
    clamp_only = '{area: '0, clamped: 1'b1, saturated: 1'b0};
    rows = '{
      '{corners(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, none},
      '{corners(5, 5, 5, 5, 5, 5, 5, 5), 1'b1, none},
      '{corners(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 1'b1, none},
      '{corners(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768),
        1'b1, none},
      // thin triangle whose truncated sides fail the inequality, D on A
      '{corners(0, 0, 1, 1, 3, 3, 0, 0), 1'b1, clamp_only},
      // collinear ABC with a zero factor
      '{corners(0, 0, 256, 0, 512, 0, 0, 0), 1'b1, none},
      '{corners(0, 0, 256, 0, 256, 256, 0, 256), 1'b0, none},
      '{corners(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767), 1'b0, none},
      '{corners(-32768, 32767, 32767, 32767, 32767, -32768, -32768, -32768), 1'b0, none},
      '{corners(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767), 1'b0, none},
      '{corners(0, 0, 32767, -32768, 0, 0, -32768, 32767), 1'b0, none},
      '{corners(-1, -1, 1, -1, 1, 1, -1, 1), 1'b0, none},
      '{corners(100, -200, -300, 400, 500, 600, -700, -800), 1'b0, none},
      '{corners(0, 0, 100, 1, 200, 1, 100, 0), 1'b0, none}
    };
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (rows[i]) send_corners(rows[i].corners, rows[i].known, rows[i].res);
    in_tvalid <= 1'b0;
    // hold until the pipe drains
    while (area_q.size() != 0) @(negedge clk);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 200 == 0) calm = ($urandom_range(0, 2) == 0);
      send_corners(random_corners(), 1'b0, none);
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;
    while (area_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d directed and %0d random corner sets, %0d results checked",
             rows.size(), N_RANDOM, n_results);
    $display("%0d results raised the clamp flag", n_clamped);
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d failures", n_fail);
      $display("Verification failed");
    end
    $finish;
  end
endmodule
